/* rtl/aes_ecb_pkg.sv */
package aes_ecb_pkg;

  typedef logic [255:0][7:0] sbox_tbl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_LOAD,
    ST_ROUND
  } state_t;

  localparam int unsigned RK_ROWS = 15;
  localparam int unsigned RK_ADDR_W = 4;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_A = 3'd1;
  localparam logic [2:0] REG_KEY_B = 3'd2;
  localparam logic [2:0] REG_KEY_C = 3'd3;
  localparam logic [2:0] REG_KEY_D = 3'd4;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = 8'h00;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = xt(aa);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] rotl1(input logic [7:0] b);
    rotl1 = {b[6:0], b[7]};
  endfunction

  // s-box built at elaboration from the field inverse and the affine map
  function automatic sbox_tbl_t gen_sbox_fwd();
    sbox_tbl_t t;
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    for (int x = 0; x < 256; x++) begin
      r = 8'h01;
      p = 8'(x);
      e = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[k]) r = gf_mul(r, p);
        p = gf_mul(p, p);
      end
      t[x] = r ^ rotl1(r) ^ rotl1(rotl1(r)) ^ rotl1(rotl1(rotl1(r)))
           ^ rotl1(rotl1(rotl1(rotl1(r)))) ^ 8'h63;
    end
    gen_sbox_fwd = t;
  endfunction

  localparam sbox_tbl_t SBOX_FWD = gen_sbox_fwd();

  function automatic sbox_tbl_t gen_sbox_inv();
    sbox_tbl_t t;
    for (int x = 0; x < 256; x++) begin
      t[SBOX_FWD[x]] = 8'(x);
    end
    gen_sbox_inv = t;
  endfunction

  localparam sbox_tbl_t SBOX_INV = gen_sbox_inv();

  function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
    get_byte = s[127 - 8*k -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int k = 0; k < 16; k++) begin
      t[127 - 8*k -: 8] = inv ? SBOX_INV[get_byte(s, k)] : SBOX_FWD[get_byte(s, k)];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8*(4*c + r) -: 8] = get_byte(s, 4*((c + 4 - r) % 4) + r);
        else t[127 - 8*(4*c + r) -: 8] = get_byte(s, 4*((c + r) % 4) + r);
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0][7:0] a;
    logic [7:0] x2;
    logic [7:0] x4;
    logic [7:0] x8;
    logic [3:0][7:0] m2;
    logic [3:0][7:0] m3;
    logic [3:0][7:0] m9;
    logic [3:0][7:0] mb;
    logic [3:0][7:0] md;
    logic [3:0][7:0] me;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = get_byte(s, 4*c + k);
        x2 = xt(a[k]);
        x4 = xt(x2);
        x8 = xt(x4);
        m2[k] = x2;
        m3[k] = x2 ^ a[k];
        m9[k] = x8 ^ a[k];
        mb[k] = x8 ^ x2 ^ a[k];
        md[k] = x8 ^ x4 ^ a[k];
        me[k] = x8 ^ x4 ^ x2;
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127 - 8*(4*c + r) -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
        else t[127 - 8*(4*c + r) -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    mix_columns = t;
  endfunction

  // one cipher round; the final round skips the column mix
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic dec, input logic last);
    logic [127:0] t;
    if (!dec) begin
      t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
      if (!last) t = mix_columns(t, 1'b0);
      t = t ^ rk;
    end else begin
      t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ rk;
      if (!last) t = mix_columns(t, 1'b1);
    end
    aes_round = t;
  endfunction

endpackage

/* rtl/aes_ecb_ram.sv */
module aes_ecb_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/aes_ecb_block_cipher.sv */
// aes block cipher, ecb mode, 128/192/256-bit keys. an item is taken when start is high and
// busy is low; its result appears on out_result_high/out_result_low for exactly one cycle
// with out_valid high, and the receiver cannot stall it. the round keys sit in a 15-row by
// 128-bit ram, one row per round, and each round reads its key from one row. with a cached
// schedule an item passes from accept through the load state and then one round state per
// round (10, 12 or 14 rounds) to its result; busy drops the cycle the result is shown. any
// register write invalidates the schedule, and the next item first expands the key at one
// 32-bit word a cycle and then passes the fetch state. registers sit at byte address 8*i:
// key_size, then key words a to d (64 bits, key byte 0 in the top bits of word a).
module aes_ecb_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  // command side
  input  logic         start,
  output logic         busy,
  input  logic         in_req_type,
  input  logic [63:0]  in_block_high,
  input  logic [63:0]  in_block_low,
  // result side
  output logic         out_valid,
  output logic [63:0]  out_result_high,
  output logic [63:0]  out_result_low,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  // configuration registers
  logic [1:0]        key_size_r;
  logic [3:0][63:0]  key_word_r;
  logic              sched_ready_r;

  // control
  aes_ecb_pkg::state_t state_r, state_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              dec_r, dec_nxt;
  logic [127:0]      blk_r, blk_nxt;
  logic [127:0]      st_r, st_nxt;

  // key expansion
  logic [5:0]        wi_r, wi_nxt;
  logic [2:0]        wj_r, wj_nxt;
  logic [7:0]        rc_r, rc_nxt;
  logic [7:0][31:0]  win_r, win_nxt;
  logic [31:0]       new_word;
  logic [31:0]       tmp_word;

  // output
  logic              out_valid_r;
  logic [127:0]      out_r, out_nxt;

  logic [1:0]        ks_eff;
  logic [3:0]        nr;
  logic [2:0]        nk_m1;
  logic [3:0]        key_cnt;
  logic              key_dec;
  logic [3:0]        raddr;
  logic [127:0]      rk;
  logic              ram_we;
  logic              cfg_wr;
  logic              last_round;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // code three runs as a 256-bit key
  assign ks_eff = (key_size_r == 2'd3) ? 2'd2 : key_size_r;
  assign nr     = 4'd10 + {1'b0, ks_eff, 1'b0};
  assign nk_m1  = 3'd3 + {ks_eff, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r    <= '0;
      key_word_r    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        aes_ecb_pkg::REG_KEY_SIZE: key_size_r    <= pwdata[1:0];
        aes_ecb_pkg::REG_KEY_A:    key_word_r[0] <= pwdata;
        aes_ecb_pkg::REG_KEY_B:    key_word_r[1] <= pwdata;
        aes_ecb_pkg::REG_KEY_C:    key_word_r[2] <= pwdata;
        aes_ecb_pkg::REG_KEY_D:    key_word_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      aes_ecb_pkg::REG_KEY_SIZE: prdata = {62'd0, key_size_r};
      aes_ecb_pkg::REG_KEY_A:    prdata = key_word_r[0];
      aes_ecb_pkg::REG_KEY_B:    prdata = key_word_r[1];
      aes_ecb_pkg::REG_KEY_C:    prdata = key_word_r[2];
      aes_ecb_pkg::REG_KEY_D:    prdata = key_word_r[3];
      default:                   prdata = '0;
    endcase
  end

  // schedule is stale after any in-range write, valid once expansion finishes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_ready_r <= 1'b0;
    end else if (cfg_wr && paddr[5:3] <= aes_ecb_pkg::REG_KEY_D) begin
      sched_ready_r <= 1'b0;
    end else if (state_r == aes_ecb_pkg::ST_EXPAND && wi_r == {nr, 2'b11}) begin
      sched_ready_r <= 1'b1;
    end
  end

  // next schedule word: key words first, then the standard recurrence over a window of
  // the last eight words
  always_comb begin
    tmp_word = win_r[0];
    if (wj_r == 3'd0) begin
      tmp_word = aes_ecb_pkg::sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'd0};
    end else if (nk_m1 == 3'd7 && wj_r == 3'd4) begin
      tmp_word = aes_ecb_pkg::sub_word(win_r[0]);
    end
    if (wi_r <= {3'd0, nk_m1}) begin
      new_word = wi_r[0] ? key_word_r[wi_r[2:1]][31:0] : key_word_r[wi_r[2:1]][63:32];
    end else begin
      new_word = win_r[nk_m1] ^ tmp_word;
    end
  end

  assign ram_we = (state_r == aes_ecb_pkg::ST_EXPAND) && (wi_r[1:0] == 2'b11);

  // round key row address: encrypt walks up from row 0, decrypt down from row nr
  assign raddr = key_dec ? (nr - key_cnt) : key_cnt;

  aes_ecb_ram #(
    .WIDTH(128),
    .DEPTH(aes_ecb_pkg::RK_ROWS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r[5:2]),
    .wdata ({win_r[2], win_r[1], win_r[0], new_word}),
    .raddr (raddr),
    .rdata (rk)
  );

  assign last_round = (cnt_r == nr);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    blk_nxt   = blk_r;
    st_nxt    = st_r;
    wi_nxt    = wi_r;
    wj_nxt    = wj_r;
    rc_nxt    = rc_r;
    win_nxt   = win_r;
    out_nxt   = out_r;
    key_cnt   = 4'd0;
    key_dec   = dec_r;
    unique case (state_r)
      aes_ecb_pkg::ST_IDLE: begin
        key_dec = in_req_type;
        if (start) begin
          dec_nxt = in_req_type;
          blk_nxt = {in_block_high, in_block_low};
          if (sched_ready_r) begin
            state_nxt = aes_ecb_pkg::ST_LOAD;
          end else begin
            state_nxt = aes_ecb_pkg::ST_EXPAND;
            wi_nxt    = 6'd0;
            wj_nxt    = 3'd0;
            rc_nxt    = aes_ecb_pkg::RCON_FIRST;
          end
        end
      end
      aes_ecb_pkg::ST_EXPAND: begin
        win_nxt = {win_r[6:0], new_word};
        wi_nxt  = wi_r + 6'd1;
        wj_nxt  = (wj_r == nk_m1) ? 3'd0 : wj_r + 3'd1;
        if (wj_r == 3'd0 && wi_r > {3'd0, nk_m1}) rc_nxt = aes_ecb_pkg::xt(rc_r);
        if (wi_r == {nr, 2'b11}) state_nxt = aes_ecb_pkg::ST_FETCH;
      end
      aes_ecb_pkg::ST_FETCH: begin
        // last row was written as this state was entered, now safe to read
        state_nxt = aes_ecb_pkg::ST_LOAD;
      end
      aes_ecb_pkg::ST_LOAD: begin
        st_nxt    = blk_r ^ rk;
        cnt_nxt   = 4'd1;
        key_cnt   = 4'd1;
        state_nxt = aes_ecb_pkg::ST_ROUND;
      end
      aes_ecb_pkg::ST_ROUND: begin
        st_nxt  = aes_ecb_pkg::aes_round(st_r, rk, dec_r, last_round);
        cnt_nxt = cnt_r + 4'd1;
        key_cnt = cnt_r + 4'd1;
        if (last_round) begin
          out_nxt   = st_nxt;
          state_nxt = aes_ecb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = aes_ecb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_ecb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == aes_ecb_pkg::ST_ROUND) && last_round;
    end
  end

  // payload and counters, qualified by the state machine
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dec_r <= dec_nxt;
    blk_r <= blk_nxt;
    st_r  <= st_nxt;
    wi_r  <= wi_nxt;
    wj_r  <= wj_nxt;
    rc_r  <= rc_nxt;
    win_r <= win_nxt;
    out_r <= out_nxt;
  end

  assign busy            = (state_r != aes_ecb_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_high = out_r[127:64];
  assign out_result_low  = out_r[63:0];

  // a result only follows the final round
  a_out_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == aes_ecb_pkg::ST_ROUND))
    else $error("result without final round");

  // the key ram is only written while expanding
  a_we_expand: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == aes_ecb_pkg::ST_EXPAND)
    else $error("round key write outside expansion");

  // rounds never start on a stale schedule
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == aes_ecb_pkg::ST_LOAD |-> sched_ready_r)
    else $error("round started with stale key schedule");

endmodule
